@@ rtl/fat12_cluster_chain_walker_top_assert.svh @@
// Assertion macros shared by the cluster chain walker RTL.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FAT12_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fat12 walker: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FAT12_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fat12 walker: next-cycle check failed");

`endif

@@ rtl/fat12_pkg.sv @@
// Package with the beat types and fixed constants of the cluster chain walker.
`default_nettype none
package fat12_pkg;

  localparam int CLUSTER_W = 12;
  localparam int OFFSET_W  = 13;
  localparam int ADDR_IN_W = 13;
  localparam int TB_W      = 14;

  localparam logic [CLUSTER_W-1:0] END_MARK    = 12'hFF8;
  localparam logic [TB_W-1:0]      TB_RESET    = 14'd4608;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_CONT  = 2'd2
  } kind_t;

  localparam logic REG_TABLE_BYTES = 1'b0;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ADDR_IN_W-1:0] byte_address;
    logic [7:0]           byte_value;
    logic [CLUSTER_W-1:0] start_cluster;
  } req_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic                 last;
    logic                 status;
  } rsp_t;

endpackage
`default_nettype wire

@@ rtl/fat12_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module fat12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/fat12_mod.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module fat12_mod #(
  parameter int DW = 13,
  parameter int SW = 14
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [SW-1:0] divisor,
  output logic               done,
  output logic      [SW-1:0] remainder
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dv;
  logic [SW:0]   trial;
  logic [SW:0]   diff;

  assign trial = {remainder, dv[DW-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dv        <= dividend;
    end else if (busy) begin
      dv <= dv << 1;
      if (trial >= {1'b0, divisor}) begin
        remainder <= diff[SW-1:0];
      end else begin
        remainder <= trial[SW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/fat12_cluster_chain_walker_top.sv @@
// Top level of the FAT12 cluster chain walker.
`default_nettype none
`include "fat12_cluster_chain_walker_top_assert.svh"

// The block keeps a FAT12 allocation table in an on-chip byte RAM that software
// fills first with write beats (kind 0). A start beat (kind 1) names a cluster,
// and the block then returns that cluster and every following cluster of the
// chain, one response beat each, until it reaches an entry of 0xFF8 or more or
// has returned CHUNK_LEN clusters; in the second case the final beat carries
// status 1 and a continue beat (kind 2) resumes the chain. The table_bytes
// register sets the table size used to wrap entry offsets (0 acts as 1, values
// above TABLE_DEPTH act as TABLE_DEPTH); write it only while the block is idle.
// A write beat goes into the table RAM as it is taken. Each cluster of a walk
// passes through the bit-serial remainder unit that wraps the entry offset (13
// steps and a done strobe), then two RAM reads on the single read port, an
// entry decode and the response load, which waits while the response side is
// stalled. A full chunk holds CHUNK_LEN clusters (64 by default). The
// response register lets the last beat of a walk wait while the next request
// beat is already taken. The table RAM has no reset; entries never written
// read back as whatever the RAM holds.
module fat12_cluster_chain_walker_top
  import fat12_pkg::*;
#(
  parameter int TABLE_DEPTH = 8192,
  parameter int CHUNK_LEN   = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel.
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req,
  // Response channel.
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_t             rsp,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int SW     = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W  = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MOD    = 6'b000010,
    ST_RDLO   = 6'b000100,
    ST_RDHI   = 6'b001000,
    ST_RDWAIT = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic [TB_W-1:0]      table_bytes;
  logic [SW-1:0]        s_use;
  logic [CLUSTER_W-1:0] cur, cur_next;
  logic [CLUSTER_W-1:0] resume_cluster;
  logic                 walk_pending;
  logic [CNT_W-1:0]     count;
  logic [ADDR_W-1:0]    hi_at;
  logic [SW-1:0]        hi_sum;
  logic [7:0]           lo_byte;
  logic [CLUSTER_W-1:0] entry;
  logic [15:0]          word;

  logic                 req_take;
  logic                 walk_go;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [7:0]           ram_rdata;

  logic                 mod_start;
  logic [OFFSET_W-1:0]  mod_dividend;
  logic                 mod_done;
  logic [SW-1:0]        mod_rem;

  logic                 rsp_load;
  rsp_t                 rsp_next;
  logic                 chunk_end;
  logic                 chain_end;

  // Configuration register: a write lands on the access phase of a beat.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_bytes <= TB_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TABLE_BYTES)) begin
      table_bytes <= pwdata[TB_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TABLE_BYTES) begin
      prdata = 32'(table_bytes);
    end
  end

  // Effective table size used as the modulus.
  always_comb begin
    if (table_bytes == '0) begin
      s_use = SW'(1);
    end else if (32'(table_bytes) > TABLE_DEPTH) begin
      s_use = SW'(TABLE_DEPTH);
    end else begin
      s_use = SW'(table_bytes);
    end
  end

  // Request acceptance: one item at a time, taken only while idle.
  assign req_ready = (state == ST_IDLE);
  assign req_take  = req_valid && req_ready;
  assign walk_go   = req_take && ((req.kind == KIND_START) ||
                                  ((req.kind == KIND_CONT) && walk_pending));

  // Table writes go straight to the RAM; addresses beyond the table are dropped.
  assign ram_we    = req_take && (req.kind == KIND_WRITE) &&
                     (32'(req.byte_address) < TABLE_DEPTH);
  assign ram_waddr = ADDR_W'(32'(req.byte_address));

  // The low byte address is the remainder itself; the high byte is read next.
  assign ram_raddr = (state == ST_RDHI) ? hi_at : ADDR_W'(mod_rem);

  fat12_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.byte_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next current cluster: the start cluster, the resume point, or the entry
  // just decoded once the beat of the current cluster has been loaded.
  always_comb begin
    cur_next = cur;
    if (walk_go) begin
      cur_next = (req.kind == KIND_START) ? req.start_cluster : resume_cluster;
    end else if ((state == ST_EMIT) && rsp_load) begin
      cur_next = entry;
    end
  end

  assign chain_end = (entry >= END_MARK);
  assign chunk_end = (count == CNT_W'(CHUNK_LEN - 1));
  assign rsp_load  = (state == ST_EMIT) && (!rsp_valid || rsp_ready);

  assign rsp_next.cluster = cur;
  assign rsp_next.last    = chain_end || chunk_end;
  assign rsp_next.status  = !chain_end && chunk_end;

  // Byte offset c + c/2 of the entry, wrapped by the remainder unit.
  assign mod_start    = walk_go || (rsp_load && !rsp_next.last);
  assign mod_dividend = OFFSET_W'(cur_next) + OFFSET_W'(cur_next >> 1);

  fat12_mod #(
    .DW (OFFSET_W),
    .SW (SW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (s_use),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign hi_sum = mod_rem + 1'b1;
  assign word   = {ram_rdata, lo_byte};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (walk_go) state_next = ST_MOD;
      ST_MOD:    if (mod_done) state_next = ST_RDLO;
      ST_RDLO:   state_next = ST_RDHI;
      ST_RDHI:   state_next = ST_RDWAIT;
      ST_RDWAIT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (rsp_load) begin
          state_next = rsp_next.last ? ST_IDLE : ST_MOD;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      walk_pending   <= 1'b0;
      resume_cluster <= '0;
      count          <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (walk_go) begin
        walk_pending <= 1'b0;
        count        <= '0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        count     <= count + 1'b1;
        if (rsp_next.status) begin
          walk_pending   <= 1'b1;
          resume_cluster <= entry;
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (state == ST_RDLO) begin
      hi_at <= (hi_sum == s_use) ? '0 : ADDR_W'(hi_sum);
    end
    if (state == ST_RDHI) begin
      lo_byte <= ram_rdata;
    end
    if (state == ST_RDWAIT) begin
      entry <= cur[0] ? word[15:4] : word[11:0];
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // The remainder unit only finishes while the walk waits for it.
  `FAT12_ASSERT_SAME(a_mod_done_in_mod, clk, rst, mod_done, state == ST_MOD)
  // Both byte addresses of an entry lie inside the table in use.
  `FAT12_ASSERT_SAME(a_lo_in_range, clk, rst, state == ST_RDLO, mod_rem < s_use)
  `FAT12_ASSERT_SAME(a_hi_in_range, clk, rst, state == ST_RDHI,
                     SW'(hi_at) < s_use)
  // A final beat leaves the pending flag equal to its status.
  `FAT12_ASSERT_NEXT(a_pending_status, clk, rst, rsp_load && rsp_next.last,
                     walk_pending == rsp.status)

endmodule
`default_nettype wire
